>>> hw/rtl/sli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the sorted key list block.
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 8;
	localparam int COUNT_W   = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic signed [KEY_W-1:0] key;
	} req_item_t;

	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] count;
	} rsp_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the request and restart the walk
		logic rd;    // read the entry at the walk index
		logic step;  // act on the entry just read and advance
		logic fin;   // close the operation: tail write and count update
		logic emit;  // load the result register
	} sli_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;  // walk reached the end, or insert into a full list
		logic out_free;   // result register can take a new item
	} sli_sts_t;

endpackage

>>> hw/rtl/sli_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_dpath
// Key memory, walk index, count and result register of the sorted list.
// ----------------------------------------------------------------------------
module sli_dpath #(
	parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sli_pkg::sli_cmd_t   cmd,
	output sli_pkg::sli_sts_t   sts,
	input  sli_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output sli_pkg::rsp_item_t  rsp
);
	import sli_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [KEY_W-1:0]        mem [DEPTH];
	logic                    op_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] rdata_q;
	logic signed [KEY_W-1:0] hold_q;
	logic                    flag_q;
	logic                    ok_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           cnt_q;
	logic                    rsp_valid_q;
	rsp_item_t               rsp_q;

	logic [AW-1:0]           idx_a;
	logic                    full;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic [KEY_W-1:0]        wdata;
	logic [CW+COUNT_W-1:0]   cnt_ext;

	assign idx_a   = idx_q[AW-1:0];
	assign full    = (cnt_q == CW'(DEPTH));
	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_q};

	assign sts.scan_done = (idx_q == cnt_q) || ((op_q == OP_INSERT) && full);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	// Insert carries the displaced key one slot up; remove pulls keys one slot down.
	always_comb begin
		we    = 1'b0;
		waddr = idx_a;
		wdata = hold_q;
		if (cmd.step) begin
			if (op_q == OP_INSERT) begin
				if (flag_q) begin
					we    = 1'b1;
					wdata = hold_q;
				end else if (rdata_q >= key_q) begin
					we    = 1'b1;
					wdata = key_q;
				end
			end else if (flag_q) begin
				we    = 1'b1;
				waddr = idx_a - AW'(1);
				wdata = rdata_q;
			end
		end else if (cmd.fin && (op_q == OP_INSERT) && !full) begin
			we    = 1'b1;
			wdata = flag_q ? hold_q : key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.opcode;
			key_q <= req.key;
		end
		if (cmd.step && !flag_q) begin
			hold_q <= rdata_q;
		end else if (cmd.step && (op_q == OP_INSERT)) begin
			hold_q <= rdata_q;
		end
		if (cmd.emit) begin
			rsp_q.ok    <= ok_q;
			rsp_q.count <= cnt_ext[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			ok_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				flag_q <= 1'b0;
			end
			if (cmd.step) begin
				idx_q <= idx_q + CW'(1);
				if (!flag_q) begin
					if (op_q == OP_INSERT) begin
						flag_q <= (rdata_q >= key_q);
					end else begin
						flag_q <= (rdata_q == key_q);
					end
				end
			end
			if (cmd.fin) begin
				if (op_q == OP_INSERT) begin
					ok_q <= !full;
					if (!full) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end else begin
					ok_q <= flag_q;
					if (flag_q) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("key count exceeds depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CW'(DEPTH))
		else $error("walk index beyond depth");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && (op_q == OP_INSERT) && !full |=> (cnt_q == $past(cnt_q) + CW'(1)) && ok_q)
		else $error("successful insert did not raise the count");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwritten while still pending");
`endif

endmodule

>>> hw/rtl/sli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_ctrl
// Sequencer that walks the key list once per operation.
// ----------------------------------------------------------------------------
module sli_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  sli_pkg::sli_sts_t  sts,
	output sli_pkg::sli_cmd_t  cmd
);
	import sli_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_FIN
	} state_t;

	state_t state_q;

	assign req_ready = (state_q == ST_IDLE);

	// Each entry is read in ST_SCAN and then compared and written in ST_CMP.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = req_valid;
			end
			ST_SCAN: begin
				cmd.fin = sts.scan_done;
				cmd.rd  = !sts.scan_done;
			end
			ST_CMP: begin
				cmd.step = 1'b1;
			end
			ST_FIN: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					state_q <= sts.scan_done ? ST_FIN : ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_SCAN;
				end
				ST_FIN: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/sorted_list_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_core
// Bounded ascending list of signed 8-bit keys with insert and remove.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_ready, req) carries one item per
// operation: opcode selects insert or remove, key is the signed key. The
// response channel (rsp_valid, rsp_ready, rsp) returns exactly one item per
// request with a success flag and the key count after the operation, reported
// modulo 32.
// Insert places the key ahead of all stored keys that are not less than it and
// fails when DEPTH keys are held. Remove deletes the first equal key and fails
// when none matches.
// Operation: the list sits in a single memory with one read and one write
// port, and the sequencer walks the held keys one entry at a time, reading
// each entry in the scan state and comparing and writing it in the compare
// state. An insert into a full list skips the walk. One request is processed
// at a time; a new request is taken only once the previous result has been
// loaded into the output register.
// Reset clears the count and the control state; the memory is not cleared and
// holds no meaningful data until written. A stalled receiver holds the result
// in the output register; the next request is still accepted and processed,
// and its result waits until the pending one has been taken.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_core #(
	parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  sli_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output sli_pkg::rsp_item_t  rsp
);
	import sli_pkg::*;

	sli_cmd_t cmd;
	sli_sts_t sts;

	// Sequencer: decides when to read, step, finish and emit.
	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: key memory, walk index, count and the result register.
	sli_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

>>> tb/sv/sli_tb_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_tb_scoreboard_pkg
// Tracks the ordered key list on the testbench side and checks every response
// item against the outcome predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
package sli_tb_scoreboard_pkg;

	import sli_pkg::*;

	class key_list_scoreboard;

		localparam int LIST_DEPTH = DEPTH_DEF;

		logic signed [KEY_W-1:0] held_keys [LIST_DEPTH];
		int                      held;
		rsp_item_t               due_q [$];
		int                      errors;
		int                      inserts_stored;
		int                      inserts_refused;
		int                      removes_hit;
		int                      removes_missed;
		int                      peak_held;
		int                      responses_seen;

		function new();
			held            = 0;
			errors          = 0;
			inserts_stored  = 0;
			inserts_refused = 0;
			removes_hit     = 0;
			removes_missed  = 0;
			peak_held       = 0;
			responses_seen  = 0;
		endfunction

		// Applies one accepted request to the shadow list and queues its outcome.
		function void note_request(req_item_t it);
			rsp_item_t               want;
			logic signed [KEY_W-1:0] k;
			int                      pos;
			k        = $signed(it.key);
			want.ok  = 1'b0;
			pos      = 0;
			while (pos < held && $signed(held_keys[pos]) < k)
				pos++;
			if (it.opcode == OP_INSERT) begin
				if (held < LIST_DEPTH) begin
					for (int j = held; j > pos; j--)
						held_keys[j] = held_keys[j-1];
					held_keys[pos] = k;
					held++;
					want.ok = 1'b1;
					inserts_stored++;
				end else begin
					inserts_refused++;
				end
			end else begin
				if (pos < held && $signed(held_keys[pos]) == k) begin
					for (int j = pos; j + 1 < held; j++)
						held_keys[j] = held_keys[j+1];
					held--;
					want.ok = 1'b1;
					removes_hit++;
				end else begin
					removes_missed++;
				end
			end
			if (held > peak_held)
				peak_held = held;
			want.count = held[COUNT_W-1:0];
			due_q.push_back(want);
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			responses_seen++;
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected response item, expected none, got ok=%0b count=%0d",
					$time, got.ok, got.count);
				return;
			end
			want = due_q.pop_front();
			if (got.ok !== want.ok) begin
				errors++;
				$display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, got.ok);
			end
			if (got.count !== want.count) begin
				errors++;
				$display("%0t: count mismatch, expected %0d, got %0d",
					$time, want.count, got.count);
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		// A key currently held, so that removes can be aimed at real entries.
		function logic signed [KEY_W-1:0] any_held_key();
			if (held == 0)
				return '0;
			return held_keys[$urandom_range(held - 1, 0)];
		endfunction

	endclass

endpackage

>>> tb/sv/tb_sorted_list_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_remove_core
// Self-checking testbench for the sorted key list with insert and remove.
// ----------------------------------------------------------------------------
// A short directed sequence exercises removal from an empty list, the extreme
// keys, duplicate keys, a missing key and an insert into a full list. A long
// random sequence follows, whose insert/remove mix changes in blocks so that
// the list repeatedly fills up and drains. Every accepted request updates a
// shadow list in the scoreboard, and every response item is compared with the
// predicted success flag and count. Both channels idle in random bursts except
// near the end of the run.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_remove_core;

	import sli_pkg::*;
	import sli_tb_scoreboard_pkg::*;

	localparam int LIST_DEPTH   = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1525;
	localparam int CALM_ITEMS   = 200;
	// The drain wait leaves room beyond a walk over a full list.
	localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 20;
	localparam int CYCLE_LIMIT  = 1000000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	// When set, neither side inserts idle cycles.
	bit calm;
	int cycle_count;

	key_list_scoreboard ledger;

	sorted_list_insert_remove_core #(
		.DEPTH(LIST_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: the slowest legal run stays far below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The block's outputs and our inputs only move at rising edges, so the
	// values seen at the falling edge are the ones the next rising edge uses.
	// A response item seen with valid and ready high here is therefore taken.
	always @(negedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			ledger.check_response(rsp);
	end

	// Receiver: long stretches of ready, broken by random stalls unless calm is set.
	initial begin
		rsp_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			rsp_ready <= 1'b1;
			repeat ($urandom_range(60, 1)) @(posedge clk);
			if (!calm && $urandom_range(2, 0) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(19, 1)) @(posedge clk);
			end
		end
	end

	// Presents one request item and returns at the rising edge that took it.
	// The caller decides whether valid stays high for the next item.
	task automatic push_request(input logic op, input logic signed [KEY_W-1:0] k);
		req_item_t it;
		bit        taken;
		it.opcode = op;
		it.key    = k;
		req       <= it;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = req_ready;
			@(posedge clk);
		end while (!taken);
		ledger.note_request(it);
	endtask

	// Drops valid and waits for the given number of cycles.
	task automatic sender_gap(input int cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds the sender back until every outstanding response item has come.
	task automatic drain_responses();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (ledger.pending() != 0);
	endtask

	// Draws one random request. Keys come from the full range, from a narrow band
	// around zero where duplicates pile up, from the held keys for removes so that
	// most removes find their target, or else from the extreme keys, -1 and zero.
	function automatic req_item_t random_request(input int insert_pct);
		req_item_t it;
		int        pick;
		it.opcode = ($urandom_range(99, 0) < insert_pct) ? OP_INSERT : OP_REMOVE;
		pick      = $urandom_range(9, 0);
		if (pick < 4)
			it.key = 8'($urandom);
		else if (pick < 7)
			it.key = $signed(8'($urandom_range(8, 0))) - 8'sd4;
		else if (it.opcode == OP_REMOVE && ledger.held > 0)
			it.key = ledger.any_held_key();
		else
			case ($urandom_range(3, 0))
				0: it.key = 8'sh80;
				1: it.key = 8'sh7F;
				2: it.key = 8'shFF;
				default: it.key = 8'sh00;
			endcase
		return it;
	endfunction

	// Keys used to top the list up to full in the directed part.
	localparam logic signed [KEY_W-1:0] FILL_KEYS [13] = '{
		8'sh7F, 8'sh80, 8'sh00, 8'sh00, 8'sh40, 8'shC0, 8'sh02,
		8'shFE, 8'sh64, 8'sh9C, 8'sh01, 8'shFF, 8'sh55
	};

	initial begin
		req_item_t it;
		int        insert_pct;
		ledger      = new();
		calm        = 1'b0;
		cycle_count = 0;
		arst_n      = 1'b0;
		req_valid   <= 1'b0;
		req         <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The list starts empty, so a remove must miss.
		push_request(OP_REMOVE, 8'sh00);
		// Extreme keys, then a duplicate pair of zeros around its neighbors.
		push_request(OP_INSERT, 8'sh7F);
		push_request(OP_INSERT, 8'sh80);
		push_request(OP_INSERT, 8'sh00);
		push_request(OP_INSERT, 8'sh00);
		push_request(OP_INSERT, 8'shFF);
		push_request(OP_INSERT, 8'sh01);
		// Only one of the two zeros may go away.
		push_request(OP_REMOVE, 8'sh00);
		// A key that was never stored.
		push_request(OP_REMOVE, 8'sh2A);
		push_request(OP_REMOVE, 8'sh80);
		push_request(OP_REMOVE, 8'sh7F);
		// Three keys are left; fill the list up to its depth.
		foreach (FILL_KEYS[i])
			push_request(OP_INSERT, FILL_KEYS[i]);
		// The list is full now, so this insert has to be refused.
		push_request(OP_INSERT, 8'sh05);
		drain_responses();

		// Random part. The insert share changes every 50 items so that the list
		// swings between empty and full many times over.
		insert_pct = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				case ($urandom_range(2, 0))
					0: insert_pct = 15;
					1: insert_pct = 50;
					default: insert_pct = 85;
				endcase
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			it = random_request(insert_pct);
			push_request(it.opcode, it.key);
			if (n == RANDOM_ITEMS / 2)
				drain_responses();
			else if (!calm && $urandom_range(5, 0) == 0)
				sender_gap($urandom_range(19, 1));
		end
		req_valid <= 1'b0;

		// Wait for the last responses, then give the block time to show any
		// stray response item before judging the run.
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d responses: %0d inserts stored, %0d refused on a full list,",
			ledger.responses_seen, ledger.inserts_stored, ledger.inserts_refused);
		$display("%0d removes found their key, %0d missed; the list peaked at %0d keys.",
			ledger.removes_hit, ledger.removes_missed, ledger.peak_held);
		if (ledger.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
